// ----- sv/button_press_classifier_assert.svh -----
// ----------------------------------------------------------------------------
// button_press_classifier_assert.svh
// Assertion macros for the button press classifier.
// ----------------------------------------------------------------------------
`ifndef BUTTON_PRESS_CLASSIFIER_ASSERT_SVH
`define BUTTON_PRESS_CLASSIFIER_ASSERT_SVH

`ifndef SYNTHESIS

// Clocked check, suspended while reset is asserted
`define BPC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs during reset
`define BPC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define BPC_ASSERT(label, prop, msg)
`define BPC_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

// ----- sv/bpc_pkg.sv -----
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared constants for the button press classifier: event codes, register
// map and register reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package bpc_pkg;

    localparam int unsigned TIME_W   = 32;
    localparam int unsigned THR_W    = 16;
    localparam int unsigned EVENT_W  = 2;
    localparam int unsigned ADDR_W   = 5;
    localparam int unsigned DATA_W   = 32;
    localparam int unsigned REG_IDX_W = 3;

    // Event codes
    localparam logic [EVENT_W-1:0] EV_NONE  = 2'd0;
    localparam logic [EVENT_W-1:0] EV_SHORT = 2'd1;
    localparam logic [EVENT_W-1:0] EV_LONG  = 2'd2;
    localparam logic [EVENT_W-1:0] EV_RESET = 2'd3;

    // Register indexes (byte address = 4 * index)
    localparam logic [REG_IDX_W-1:0] REG_ENABLE        = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_SHORT_MIN     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_LONG_MIN      = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_RESET_MIN     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_RELEASE_GRACE = 3'd4;

    // Register reset values
    localparam logic             ENABLE_RST        = 1'b0;
    localparam logic [THR_W-1:0] SHORT_MIN_RST     = 16'd50;
    localparam logic [THR_W-1:0] LONG_MIN_RST      = 16'd1500;
    localparam logic [THR_W-1:0] RESET_MIN_RST     = 16'd10000;
    localparam logic [THR_W-1:0] RELEASE_GRACE_RST = 16'd60;

endpackage

`default_nettype wire

// ----- sv/button_press_classifier.sv -----
// Path: sample transaction -> input register -> result register -> event.
// Throughput: one sample per cycle unless event_ready stalls; an input
// register feeds single-pass press logic that writes result and press state.
// Reset (rst_n low, asynchronous): press state cleared, no item in flight,
// registers back to enable 0, short 50, long 1500, reset 10000, grace 60 ms.
// ----------------------------------------------------------------------------
// button_press_classifier
// Classifies active-low button presses as short, long or factory reset from
// timestamped pin samples, with release debouncing and wrapping ms time.
// ----------------------------------------------------------------------------
`default_nettype none

`include "button_press_classifier_assert.svh"

module button_press_classifier (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // configuration port
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [bpc_pkg::ADDR_W-1:0]        paddr,
    input  wire logic [bpc_pkg::DATA_W-1:0]        pwdata,
    output logic      [bpc_pkg::DATA_W-1:0]        prdata,
    output logic                                   pready,
    // sample channel
    input  wire logic                              sample_valid,
    output logic                                   sample_ready,
    input  wire logic                              pin_level,
    input  wire logic [bpc_pkg::TIME_W-1:0]        now_ms,
    // event channel
    output logic                                   event_valid,
    input  wire logic                              event_ready,
    output logic      [bpc_pkg::EVENT_W-1:0]       event_res
);

    import bpc_pkg::*;

    // configuration registers
    logic              enable_reg;
    logic [THR_W-1:0]  short_min_reg;
    logic [THR_W-1:0]  long_min_reg;
    logic [THR_W-1:0]  reset_min_reg;
    logic [THR_W-1:0]  grace_reg;

    logic                 cfg_wr;
    logic [REG_IDX_W-1:0] cfg_idx;

    // input stage
    logic              in_vld_reg;
    logic              pin_level_reg;
    logic [TIME_W-1:0] now_ms_reg;

    // result stage
    logic               out_vld_reg;
    logic [EVENT_W-1:0] event_res_reg;

    // press state
    logic              held_reg,        held_next;
    logic              rst_rep_reg,     rst_rep_next;
    logic [TIME_W-1:0] press_start_reg, press_start_next;
    logic              rel_pend_reg,    rel_pend_next;
    logic [TIME_W-1:0] rel_start_reg,   rel_start_next;
    logic [EVENT_W-1:0] event_next;

    logic              advance;
    logic              down;
    logic [TIME_W-1:0] hold_dur;
    logic [TIME_W-1:0] rel_dur;
    logic [TIME_W-1:0] press_dur;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_idx = paddr[ADDR_W-1:2];
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= ENABLE_RST;
            short_min_reg <= SHORT_MIN_RST;
            long_min_reg  <= LONG_MIN_RST;
            reset_min_reg <= RESET_MIN_RST;
            grace_reg     <= RELEASE_GRACE_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_ENABLE:        enable_reg    <= pwdata[0];
                REG_SHORT_MIN:     short_min_reg <= pwdata[THR_W-1:0];
                REG_LONG_MIN:      long_min_reg  <= pwdata[THR_W-1:0];
                REG_RESET_MIN:     reset_min_reg <= pwdata[THR_W-1:0];
                REG_RELEASE_GRACE: grace_reg     <= pwdata[THR_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_ENABLE:        prdata = {{(DATA_W-1){1'b0}}, enable_reg};
            REG_SHORT_MIN:     prdata = {{(DATA_W-THR_W){1'b0}}, short_min_reg};
            REG_LONG_MIN:      prdata = {{(DATA_W-THR_W){1'b0}}, long_min_reg};
            REG_RESET_MIN:     prdata = {{(DATA_W-THR_W){1'b0}}, reset_min_reg};
            REG_RELEASE_GRACE: prdata = {{(DATA_W-THR_W){1'b0}}, grace_reg};
            default:           prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline control
    // ------------------------------------------------------------------
    assign advance      = in_vld_reg & (~out_vld_reg | event_ready);
    assign sample_ready = ~in_vld_reg | advance;
    assign event_valid  = out_vld_reg;
    assign event_res    = event_res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (sample_ready)
                in_vld_reg <= sample_valid;
            if (advance)
                out_vld_reg <= 1'b1;
            else if (event_ready)
                out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_valid && sample_ready)
        begin
            pin_level_reg <= pin_level;
            now_ms_reg    <= now_ms;
        end
        if (advance)
            event_res_reg <= event_next;
    end

    // ------------------------------------------------------------------
    // Press logic
    // ------------------------------------------------------------------
    assign down      = ~pin_level_reg;
    assign hold_dur  = now_ms_reg - press_start_reg;
    assign rel_dur   = now_ms_reg - rel_start_reg;
    assign press_dur = rel_start_reg - press_start_reg;

    always_comb
    begin
        held_next        = held_reg;
        rst_rep_next     = rst_rep_reg;
        press_start_next = press_start_reg;
        rel_pend_next    = rel_pend_reg;
        rel_start_next   = rel_start_reg;
        event_next       = EV_NONE;

        if (enable_reg)
        begin
            if (down && !held_reg)
            begin
                // start of a new press
                held_next        = 1'b1;
                rst_rep_next     = 1'b0;
                press_start_next = now_ms_reg;
                rel_pend_next    = 1'b0;
            end
            else if (down)
            begin
                // bounce cancels a pending release
                rel_pend_next = 1'b0;
                if (!rst_rep_reg && hold_dur >= {{(TIME_W-THR_W){1'b0}}, reset_min_reg})
                begin
                    rst_rep_next = 1'b1;
                    event_next   = EV_RESET;
                end
            end
            else if (held_reg)
            begin
                if (!rel_pend_reg)
                begin
                    rel_pend_next  = 1'b1;
                    rel_start_next = now_ms_reg;
                end
                else if (rel_dur >= {{(TIME_W-THR_W){1'b0}}, grace_reg})
                begin
                    // release persisted: press is over
                    held_next     = 1'b0;
                    rel_pend_next = 1'b0;
                    if (rst_rep_reg)
                        rst_rep_next = 1'b0;
                    else if (press_dur >= {{(TIME_W-THR_W){1'b0}}, reset_min_reg})
                        event_next = EV_RESET;
                    else if (press_dur >= {{(TIME_W-THR_W){1'b0}}, long_min_reg})
                        event_next = EV_LONG;
                    else if (press_dur >= {{(TIME_W-THR_W){1'b0}}, short_min_reg})
                        event_next = EV_SHORT;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg        <= 1'b0;
            rst_rep_reg     <= 1'b0;
            press_start_reg <= '0;
            rel_pend_reg    <= 1'b0;
            rel_start_reg   <= '0;
        end
        else if (advance)
        begin
            held_reg        <= held_next;
            rst_rep_reg     <= rst_rep_next;
            press_start_reg <= press_start_next;
            rel_pend_reg    <= rel_pend_next;
            rel_start_reg   <= rel_start_next;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `BPC_ASSERT(a_pend_needs_held, rel_pend_reg |-> held_reg,
        "release pending while no press is held")
    `BPC_ASSERT(a_report_needs_held, rst_rep_reg |-> held_reg,
        "factory reset marked reported outside a press")
    `BPC_ASSERT(a_advance_fills_out, advance |=> out_vld_reg,
        "processed sample did not produce an event transaction")

endmodule

`default_nettype wire

// ----- tb/button_press_classifier_test.sv -----
// ----------------------------------------------------------------------------
// button_press_classifier_test
// Self-checking bench for the button press classifier. Timestamped pin samples
// (directed press scenarios, then random well-formed presses with bounce and
// wrap, plus noise) are sent through the sample channel with random gaps and
// event stalls. A behavioral press model predicts every event, which is checked
// in order. Thresholds are reprogrammed between phases through the APB port,
// including disabled, all-zero and all-maximum settings, with read-back checks.
// ----------------------------------------------------------------------------
`default_nettype none

module button_press_classifier_test;

    import bpc_pkg::*;

    localparam int unsigned IDLE_LIMIT  = 2000;
    localparam int unsigned DRAIN_WAIT  = 10;
    localparam int unsigned REPORT_MAX  = 10;

    typedef struct packed {
        logic                pin;
        logic [TIME_W-1:0]   stamp;
    } pin_sample_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [ADDR_W-1:0]      paddr = '0;
    logic [DATA_W-1:0]      pwdata = '0;
    logic [DATA_W-1:0]      prdata;
    logic                   pready;
    logic                   sample_valid = 1'b0;
    logic                   sample_ready;
    logic                   pin_level = 1'b1;
    logic [TIME_W-1:0]      now_ms = '0;
    logic                   event_valid;
    logic                   event_ready = 1'b0;
    logic [EVENT_W-1:0]     event_res;

    // Press model: configuration and state
    logic                   cfg_enable    = ENABLE_RST;
    logic [THR_W-1:0]       cfg_short_min = SHORT_MIN_RST;
    logic [THR_W-1:0]       cfg_long_min  = LONG_MIN_RST;
    logic [THR_W-1:0]       cfg_reset_min = RESET_MIN_RST;
    logic [THR_W-1:0]       cfg_grace     = RELEASE_GRACE_RST;
    logic                   btn_held      = 1'b0;
    logic                   reset_sent    = 1'b0;
    logic [TIME_W-1:0]      press_start   = '0;
    logic                   release_seen  = 1'b0;
    logic [TIME_W-1:0]      release_start = '0;

    pin_sample_t            pending_samples[$];
    logic [EVENT_W-1:0]     expected_events[$];
    logic [TIME_W-1:0]      clock_ms;

    int unsigned            samples_queued = 0;
    int unsigned            samples_taken  = 0;
    int unsigned            mismatches     = 0;
    int unsigned            settings_used  = 0;
    int unsigned            idle_cycles    = 0;
    int unsigned            event_tally[4] = '{0, 0, 0, 0};

    bit                     sample_took = 1'b0;
    bit                     event_took  = 1'b0;
    bit                     send_burst  = 1'b0;
    bit                     recv_burst  = 1'b0;
    int unsigned            sample_gap  = 0;
    int unsigned            recv_stall  = 0;

    button_press_classifier i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .pin_level    (pin_level),
        .now_ms       (now_ms),
        .event_valid  (event_valid),
        .event_ready  (event_ready),
        .event_res    (event_res)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------------
    // Press model
    // ------------------------------------------------------------------------
    function automatic logic [EVENT_W-1:0] predict_event(input logic pin,
                                                         input logic [TIME_W-1:0] stamp);
        logic [TIME_W-1:0] elapsed;
        if (!cfg_enable)
            return EV_NONE;
        if (!pin && !btn_held)
        begin
            btn_held     = 1'b1;
            reset_sent   = 1'b0;
            press_start  = stamp;
            release_seen = 1'b0;
            return EV_NONE;
        end
        if (!pin)
        begin
            // bounce or continued hold: cancel any pending release
            release_seen = 1'b0;
            elapsed = stamp - press_start;
            if (!reset_sent && elapsed >= {16'd0, cfg_reset_min})
            begin
                reset_sent = 1'b1;
                return EV_RESET;
            end
            return EV_NONE;
        end
        if (!btn_held)
            return EV_NONE;
        if (!release_seen)
        begin
            release_seen  = 1'b1;
            release_start = stamp;
            return EV_NONE;
        end
        elapsed = stamp - release_start;
        if (elapsed < {16'd0, cfg_grace})
            return EV_NONE;
        btn_held     = 1'b0;
        release_seen = 1'b0;
        if (reset_sent)
        begin
            reset_sent = 1'b0;
            return EV_NONE;
        end
        elapsed = release_start - press_start;
        if (elapsed >= {16'd0, cfg_reset_min})
            return EV_RESET;
        if (elapsed >= {16'd0, cfg_long_min})
            return EV_LONG;
        if (elapsed >= {16'd0, cfg_short_min})
            return EV_SHORT;
        return EV_NONE;
    endfunction

    function automatic logic [DATA_W-1:0] register_image(input logic [REG_IDX_W-1:0] idx);
        case (idx)
            REG_ENABLE:        return {31'd0, cfg_enable};
            REG_SHORT_MIN:     return {16'd0, cfg_short_min};
            REG_LONG_MIN:      return {16'd0, cfg_long_min};
            REG_RESET_MIN:     return {16'd0, cfg_reset_min};
            REG_RELEASE_GRACE: return {16'd0, cfg_grace};
            default:           return '0;
        endcase
    endfunction

    task automatic note_mismatch(input string what, input logic [DATA_W-1:0] want,
                                 input logic [DATA_W-1:0] got);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("[%0t] MISMATCH %s: expected %0h, got %0h", $realtime, what, want, got);
    endtask

    // ------------------------------------------------------------------------
    // Register access
    // ------------------------------------------------------------------------
    task automatic check_register(input logic [REG_IDX_W-1:0] idx);
        logic [DATA_W-1:0] got;
        logic [DATA_W-1:0] mask;
        mask = (idx == REG_ENABLE) ? 32'h1 : 32'hFFFF;
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = {idx, 2'b00};
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        got = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        if ((got & mask) !== register_image(idx))
            note_mismatch($sformatf("register %0d read-back", idx), register_image(idx), got);
    endtask

    task automatic set_register(input logic [REG_IDX_W-1:0] idx, input logic [THR_W-1:0] value);
        logic [DATA_W-1:0] junk;
        junk = $urandom();
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        // unused upper bits carry junk; only the field width must matter
        pwdata  = (idx == REG_ENABLE) ? {junk[31:1], value[0]} : {junk[31:16], value};
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        case (idx)
            REG_ENABLE:        cfg_enable    = value[0];
            REG_SHORT_MIN:     cfg_short_min = value;
            REG_LONG_MIN:      cfg_long_min  = value;
            REG_RESET_MIN:     cfg_reset_min = value;
            REG_RELEASE_GRACE: cfg_grace     = value;
            default: ;
        endcase
        check_register(idx);
    endtask

    task automatic configure(input logic en, input logic [THR_W-1:0] short_min,
                             input logic [THR_W-1:0] long_min,
                             input logic [THR_W-1:0] reset_min,
                             input logic [THR_W-1:0] grace);
        set_register(REG_RELEASE_GRACE, grace);
        set_register(REG_RESET_MIN, reset_min);
        set_register(REG_LONG_MIN, long_min);
        set_register(REG_SHORT_MIN, short_min);
        set_register(REG_ENABLE, {15'd0, en});
        settings_used++;
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    task automatic push_sample(input logic pin, input logic [TIME_W-1:0] stamp);
        pending_samples.push_back('{pin: pin, stamp: stamp});
        samples_queued++;
    endtask

    // One press: optional idle, a hold with possible bounce, then a release
    // that is sure to outlast the grace time.
    task automatic add_press();
        int unsigned span;
        case ($urandom_range(0, 2))
            0:       span = cfg_short_min + 8;
            1:       span = cfg_long_min / 2 + 8;
            default: span = cfg_reset_min / 3 + 8;
        endcase
        repeat ($urandom_range(0, 2))
        begin
            push_sample(1'b1, clock_ms);
            clock_ms += $urandom_range(0, 50);
        end
        repeat ($urandom_range(1, 6))
        begin
            push_sample(1'b0, clock_ms);
            clock_ms += $urandom_range(0, span);
            if ($urandom_range(0, 5) == 0)
            begin
                push_sample(1'b1, clock_ms);
                clock_ms += $urandom_range(0, cfg_grace);
            end
        end
        repeat ($urandom_range(0, 3))
        begin
            push_sample(1'b1, clock_ms);
            clock_ms += $urandom_range(0, cfg_grace / 2 + 2);
        end
        push_sample(1'b1, clock_ms);
        clock_ms += cfg_grace + $urandom_range(0, 3);
        push_sample(1'b1, clock_ms);
        clock_ms += $urandom_range(0, 20);
    endtask

    task automatic random_traffic(input int unsigned count);
        int unsigned first;
        first = samples_queued;
        clock_ms = $urandom();
        while (samples_queued - first < count)
        begin
            case ($urandom_range(0, 9))
                0: push_sample(1'($urandom_range(0, 1)), $urandom());
                1: clock_ms = $urandom();
                default: add_press();
            endcase
        end
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (samples_taken != samples_queued || expected_events.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Sample driver
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        pin_sample_t next_item;
        if (rst_n && (!sample_valid || sample_took))
        begin
            if (sample_took)
            begin
                if ($urandom_range(0, 31) == 0)
                    send_burst = !send_burst;
                sample_gap = send_burst ? 0 : $urandom_range(0, 10);
            end
            if (sample_gap > 0)
            begin
                sample_gap--;
                sample_valid <= 1'b0;
            end
            else if (pending_samples.size() > 0)
            begin
                next_item = pending_samples.pop_front();
                sample_valid <= 1'b1;
                pin_level    <= next_item.pin;
                now_ms       <= next_item.stamp;
            end
            else
                sample_valid <= 1'b0;
        end
    end

    // Event receiver: hold ready low for a random stall after each transaction
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (event_took)
            begin
                if ($urandom_range(0, 31) == 0)
                    recv_burst = !recv_burst;
                recv_stall = recv_burst ? 0 : $urandom_range(0, 10);
            end
            if (recv_stall > 0)
            begin
                recv_stall--;
                event_ready <= 1'b0;
            end
            else
                event_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor, checker and watchdog
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        logic [EVENT_W-1:0] want;
        if (rst_n)
        begin
            sample_took = sample_valid && sample_ready;
            event_took  = event_valid && event_ready;
            // check before predicting: a result never belongs to this edge's sample
            if (event_took)
            begin
                if (expected_events.size() == 0)
                    note_mismatch("event with none pending", '0, DATA_W'(event_res));
                else
                begin
                    want = expected_events.pop_front();
                    if (event_res !== want)
                        note_mismatch("event_res", DATA_W'(want), DATA_W'(event_res));
                end
            end
            if (sample_took)
            begin
                want = predict_event(pin_level, now_ms);
                expected_events.push_back(want);
                event_tally[want]++;
                samples_taken++;
            end
            if (sample_took || event_took || psel)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Watchdog: no transaction for %0d cycles", IDLE_LIMIT);
                $display("button_press_classifier verification failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // reset values, then samples while disabled
        for (int i = 0; i <= REG_RELEASE_GRACE; i++)
            check_register(i[REG_IDX_W-1:0]);
        @(posedge clk);
        push_sample(1'b0, 32'd10);
        push_sample(1'b1, 32'd5000);
        wait_idle();

        // default thresholds, enabled
        configure(1'b1, SHORT_MIN_RST, LONG_MIN_RST, RESET_MIN_RST, RELEASE_GRACE_RST);
        push_sample(1'b1, 32'd0);           // idle release
        push_sample(1'b0, 32'd100);
        push_sample(1'b1, 32'd130);
        push_sample(1'b0, 32'd140);         // bounce during hold
        push_sample(1'b1, 32'd200);
        push_sample(1'b1, 32'd260);         // short
        push_sample(1'b0, 32'd1000);
        push_sample(1'b1, 32'd1020);
        push_sample(1'b1, 32'd1080);        // below short
        push_sample(1'b0, 32'd2000);
        push_sample(1'b1, 32'd3600);
        push_sample(1'b1, 32'd3660);        // long
        push_sample(1'b0, 32'd5000);
        push_sample(1'b0, 32'd15000);       // factory reset while held
        push_sample(1'b0, 32'd16000);
        push_sample(1'b1, 32'd16010);
        push_sample(1'b1, 32'd16100);       // release after reset: nothing
        push_sample(1'b0, 32'hFFFF_FFF0);
        push_sample(1'b1, 32'h0000_0640);
        push_sample(1'b1, 32'h0000_06A0);   // long across the time wrap
        wait_idle();

        // all thresholds and grace at zero
        configure(1'b1, 16'd0, 16'd0, 16'd0, 16'd0);
        push_sample(1'b0, 32'd7);
        push_sample(1'b0, 32'd7);
        push_sample(1'b1, 32'd7);
        push_sample(1'b1, 32'd7);
        push_sample(1'b0, 32'd9);
        push_sample(1'b1, 32'd9);
        push_sample(1'b1, 32'd9);
        random_traffic(150);
        wait_idle();

        // all at maximum
        configure(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        random_traffic(250);
        wait_idle();

        for (int phase = 0; phase < 5; phase++)
        begin
            configure(phase != 2, THR_W'($urandom_range(0, 300)),
                      THR_W'($urandom_range(0, 4000)),
                      THR_W'($urandom_range(0, 15000)),
                      THR_W'($urandom_range(0, 300)));
            random_traffic(phase == 2 ? 100 : 300);
            wait_idle();
        end

        repeat (DRAIN_WAIT) @(negedge clk);
        if (expected_events.size() != 0)
            note_mismatch("events never delivered", '0, expected_events.size());

        $display("Covered %0d samples under %0d register settings, %0d mismatches.",
                 samples_taken, settings_used, mismatches);
        $display("Events: none %0d, short %0d, long %0d, factory reset %0d.",
                 event_tally[EV_NONE], event_tally[EV_SHORT], event_tally[EV_LONG],
                 event_tally[EV_RESET]);
        if (mismatches == 0)
            $display("button_press_classifier verification clean");
        else
            $display("button_press_classifier verification failed");
        $finish;
    end

endmodule

`default_nettype wire
